/* sv/b64c_pkg.sv */
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and alphabet helpers for the base64url codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [7:0] BYTE_MASK = 8'hFF;
  localparam logic [5:0] SIX_MASK  = 6'h3F;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } b64c_mode_t;

  typedef enum logic {
    REQ_DATA = 1'b0,
    REQ_END  = 1'b1
  } b64c_req_t;

  // One queued job: one or two results of a single accepted item.
  typedef struct packed {
    logic       two;      // a second character follows
    logic       enc;      // map the six-bit values through the alphabet
    logic       has;
    logic       last;
    logic       stopped;
    logic [7:0] b0;       // raw byte, or six-bit value in the low bits
    logic [5:0] b1;       // second six-bit value
  } b64c_entry_t;

  // Six-bit value of a character; bit 6 set when it belongs to the alphabet.
  function automatic logic [6:0] b64c_char_value(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'd0;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      r = {1'b1, t[5:0]};
    end else if (c == 8'h2D) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // Alphabet character for a six-bit value.
  function automatic logic [7:0] b64c_alpha(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, v};
    if (v < 6'd26) begin
      r = w + 8'h41;
    end else if (v < 6'd52) begin
      r = w - 8'd26 + 8'h61;
    end else if (v < 6'd62) begin
      r = w - 8'd52 + 8'h30;
    end else if (v == 6'd62) begin
      r = 8'h2D;
    end else begin
      r = 8'h5F;
    end
    return r;
  endfunction

endpackage

/* sv/b64c_front.sv */
// ----------------------------------------------------------------------------
// b64c_front
// Accepts items, keeps the bit accumulator and queues the results they cause.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_mode,
  input  logic                  take,
  input  logic                  req_type,
  input  logic [7:0]            data_byte,
  output logic                  q_wr_en,
  output b64c_pkg::b64c_entry_t q_wr_data
);
  import b64c_pkg::*;

  b64c_mode_t  mode_r, mode_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        stop_r, stop_nxt;

  logic [11:0] enc_sh;
  logic [11:0] dec_sh;
  logic [6:0]  cval;
  b64c_entry_t ent;
  logic        emit;

  assign cfg_ready = 1'b1;
  assign enc_sh    = {acc_r[3:0], data_byte};
  assign cval      = b64c_char_value(data_byte);
  assign dec_sh    = {acc_r[5:0], cval[5:0]};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    ent      = '0;
    emit     = 1'b0;
    if (cfg_valid && cfg_ready) begin
      mode_nxt = b64c_mode_t'(cfg_mode);
      acc_nxt  = '0;
      cnt_nxt  = '0;
      stop_nxt = 1'b0;
    end else if (take) begin
      if (b64c_req_t'(req_type) == REQ_END) begin
        // flush leftover bits, zero padded, then clear the stream
        emit     = 1'b1;
        ent.last = 1'b1;
        if (mode_r == MODE_ENCODE && cnt_r == 4'd2) begin
          ent.enc = 1'b1;
          ent.has = 1'b1;
          ent.b0  = {2'b00, acc_r[1:0], 4'b0000};
        end else if (mode_r == MODE_ENCODE && cnt_r == 4'd4) begin
          ent.enc = 1'b1;
          ent.has = 1'b1;
          ent.b0  = {2'b00, acc_r[3:0], 2'b00};
        end else begin
          ent.stopped = (mode_r == MODE_DECODE) ? stop_r : 1'b0;
        end
        acc_nxt  = '0;
        cnt_nxt  = '0;
        stop_nxt = 1'b0;
      end else if (mode_r == MODE_ENCODE) begin
        emit    = 1'b1;
        ent.enc = 1'b1;
        ent.has = 1'b1;
        acc_nxt = enc_sh;
        case (cnt_r)
          4'd0: begin
            ent.b0  = {2'b00, enc_sh[7:2]};
            cnt_nxt = 4'd2;
          end
          4'd2: begin
            ent.b0  = {2'b00, enc_sh[9:4]};
            cnt_nxt = 4'd4;
          end
          default: begin
            ent.two = 1'b1;
            ent.b0  = {2'b00, enc_sh[11:6]};
            ent.b1  = enc_sh[5:0] & SIX_MASK;
            cnt_nxt = 4'd0;
          end
        endcase
      end else if (!stop_r) begin
        if (!cval[6]) begin
          stop_nxt = 1'b1;
        end else begin
          acc_nxt = dec_sh;
          ent.has = 1'b1;
          case (cnt_r)
            4'd6: begin
              emit    = 1'b1;
              ent.b0  = dec_sh[11:4];
              cnt_nxt = 4'd4;
            end
            4'd4: begin
              emit    = 1'b1;
              ent.b0  = dec_sh[9:2];
              cnt_nxt = 4'd2;
            end
            4'd2: begin
              emit    = 1'b1;
              ent.b0  = dec_sh[7:0] & BYTE_MASK;
              cnt_nxt = 4'd0;
            end
            default: begin
              cnt_nxt = 4'd6;
            end
          endcase
        end
      end
    end
  end

  assign q_wr_en   = emit;
  assign q_wr_data = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
      acc_r  <= '0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

/* sv/b64c_queue.sv */
// ----------------------------------------------------------------------------
// b64c_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64c_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  b64c_pkg::b64c_entry_t wr_data,
  input  logic                  rd_en,
  output b64c_pkg::b64c_entry_t rd_data,
  output logic                  not_empty,
  output logic                  full
);
  import b64c_pkg::*;

  b64c_entry_t    mem [QDEPTH];
  logic [QAW-1:0] wptr_r, wptr_nxt;
  logic [QAW-1:0] rptr_r, rptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign rd_data   = mem[rptr_r];

  always_comb begin
    wptr_nxt = wr_en ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = rd_en ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (QAW+1)'(wr_en) - (QAW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* sv/b64c_back.sv */
// ----------------------------------------------------------------------------
// b64c_back
// Splits queued jobs into single results and maps values to characters.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64c_pkg::b64c_entry_t head,
  input  logic                  head_valid,
  output logic                  head_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte,
  output logic                  has_byte,
  output logic                  last,
  output logic                  stopped
);
  import b64c_pkg::*;

  logic       sel_r, sel_nxt;
  logic       beat;
  logic [5:0] six;

  assign empty = !head_valid;
  assign beat  = pop && head_valid;
  assign six   = sel_r ? head.b1 : head.b0[5:0];

  assign out_byte = head.enc ? b64c_alpha(six) : head.b0;
  assign has_byte = head.has;
  assign last     = head.last;
  assign stopped  = head.stopped;

  // advance to the second character, otherwise drop the job
  always_comb begin
    sel_nxt  = sel_r;
    head_pop = 1'b0;
    if (beat) begin
      if (head.two && !sel_r) begin
        sel_nxt = 1'b1;
      end else begin
        sel_nxt  = 1'b0;
        head_pop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

/* sv/base64url_codec_core.sv */
// ----------------------------------------------------------------------------
// base64url_codec_core
// Streaming base64url codec (URL-safe alphabet, no padding characters).
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | in_push / in_full      | in_req_type, in_data_byte
//  result   | out_pop / out_empty    | out_out_byte, out_has_byte, out_last,
//           |                        | out_stopped
//  config   | cfg_valid / cfg_ready  | cfg_mode (0 encode, 1 decode)
//
// One input beat is taken per cycle while the job queue has room; results
// leave at one per cycle while out_pop is high and a job is queued, so an
// encoded byte giving two characters costs two result beats. The results
// of a beat are registered in the job queue and presented from its head.
// Reset is synchronous and active low; it selects encode and clears the
// stream state. in_full rises only when all four queue slots hold jobs.
//
module base64url_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_mode,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_req_type,
  input  logic [7:0] in_data_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_out_byte,
  output logic       out_has_byte,
  output logic       out_last,
  output logic       out_stopped
);
  import b64c_pkg::*;

  logic        take;
  logic        q_wr_en;
  b64c_entry_t q_wr_data;
  b64c_entry_t q_head;
  logic        q_not_empty;
  logic        q_full;
  logic        q_pop;

  // accept a beat whenever the queue has a free slot
  assign in_full = q_full;
  assign take    = in_push && !q_full;

  // front: classify the beat, update the accumulator, queue its results
  b64c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_mode  (cfg_mode),
    .take      (take),
    .req_type  (in_req_type),
    .data_byte (in_data_byte),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data)
  );

  // hold jobs so that front and back stall independently
  b64c_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_wr_en),
    .wr_data   (q_wr_data),
    .rd_en     (q_pop),
    .rd_data   (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // back: present one result per beat, two for a double character job
  b64c_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_not_empty),
    .head_pop   (q_pop),
    .empty      (out_empty),
    .pop        (out_pop),
    .out_byte   (out_out_byte),
    .has_byte   (out_has_byte),
    .last       (out_last),
    .stopped    (out_stopped)
  );

endmodule
